FILE: design/morton_neighbor_cell_code_unit_macros.svh
// ----------------------------------------------------------------------------
// morton neighbor cell code unit - assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef MORTON_NEIGHBOR_CELL_CODE_UNIT_MACROS_SVH
`define MORTON_NEIGHBOR_CELL_CODE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define MNCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled during reset
`define MNCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define MNCC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MNCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/mncc_pkg.sv
// ----------------------------------------------------------------------------
// mncc_pkg
// shared constants, types and bit-shuffle functions of the neighbor code unit
// ----------------------------------------------------------------------------
package mncc_pkg;

    // grid geometry
    localparam int COORD_BITS = 10;
    localparam int CODE_BITS  = 3 * COORD_BITS;
    localparam int LVL_BITS   = 4;
    localparam int POS_BITS   = COORD_BITS + 3;
    localparam int SH_BITS    = $clog2(COORD_BITS + 1);
    localparam int CMP_BITS   = (SH_BITS > LVL_BITS) ? SH_BITS : LVL_BITS;

    // morton lanes
    localparam int LANE_X = 2;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 0;

    // request tdata layout
    localparam int LEVEL_LSB  = CODE_BITS;
    localparam int STEP_X_LSB = LEVEL_LSB + LVL_BITS;
    localparam int STEP_Y_LSB = STEP_X_LSB + 2;
    localparam int STEP_Z_LSB = STEP_Y_LSB + 2;
    localparam int SUB_X_LSB  = STEP_Z_LSB + 2;
    localparam int SUB_Y_LSB  = SUB_X_LSB + 2;
    localparam int SUB_Z_LSB  = SUB_Y_LSB + 2;
    localparam int IN_USED    = SUB_Z_LSB + 2;
    localparam int IN_DATA_BITS  = ((IN_USED + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((CODE_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic [LVL_BITS-1:0]  level;
        logic [1:0]           step_x;
        logic [1:0]           step_y;
        logic [1:0]           step_z;
        logic [1:0]           sub_x;
        logic [1:0]           sub_y;
        logic [1:0]           sub_z;
    } t_req;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic                 outside;
    } t_res;

    // shift control shared by the three axes
    typedef struct packed {
        logic [SH_BITS-1:0] cell_sh;
        logic               quarter_en;
        logic [SH_BITS-1:0] quarter_sh;
    } t_shift;

    function automatic logic [COORD_BITS-1:0] mncc_pick(
        input logic [CODE_BITS-1:0] code,
        input int                   lane
    );
        logic [COORD_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < COORD_BITS; i++) begin
            r[i] = code[3 * i + lane];
        end
        return r;
    endfunction

    function automatic logic [CODE_BITS-1:0] mncc_weave(
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y,
        input logic [COORD_BITS-1:0] z
    );
        logic [CODE_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < COORD_BITS; i++) begin
            r[3 * i + LANE_X] = x[i];
            r[3 * i + LANE_Y] = y[i];
            r[3 * i + LANE_Z] = z[i];
        end
        return r;
    endfunction

endpackage

FILE: design/mncc_axis.sv
// ----------------------------------------------------------------------------
// mncc_axis
// moves one coordinate by whole and quarter cells and checks the grid bounds
// ----------------------------------------------------------------------------
module mncc_axis (
    input  logic [mncc_pkg::COORD_BITS-1:0] i_coord,
    input  logic [1:0]                      i_step,
    input  logic [1:0]                      i_sub,
    input  mncc_pkg::t_shift                i_shift,
    output logic [mncc_pkg::COORD_BITS-1:0] o_coord,
    output logic                            o_outside
);
    import mncc_pkg::*;

    logic signed [POS_BITS-1:0] step_ext;
    logic signed [POS_BITS-1:0] sub_ext;
    logic signed [POS_BITS-1:0] cell_off;
    logic signed [POS_BITS-1:0] quarter_off;
    logic signed [POS_BITS-1:0] coord_ext;
    logic signed [POS_BITS-1:0] pos;

    // 2-bit fields are two's complement, pattern 10 is -2
    assign step_ext    = {{(POS_BITS-2){i_step[1]}}, i_step};
    assign sub_ext     = {{(POS_BITS-2){i_sub[1]}}, i_sub};
    assign cell_off    = step_ext <<< i_shift.cell_sh;
    assign quarter_off = i_shift.quarter_en ? (sub_ext <<< i_shift.quarter_sh) : '0;
    assign coord_ext   = {{(POS_BITS-COORD_BITS){1'b0}}, i_coord};
    assign pos         = coord_ext + cell_off + quarter_off;

    // negative or at/above 2^COORD_BITS
    assign o_outside = pos[POS_BITS-1] | (|pos[POS_BITS-2:COORD_BITS]);
    assign o_coord   = pos[COORD_BITS-1:0];

endmodule

FILE: design/mncc_calc.sv
// ----------------------------------------------------------------------------
// mncc_calc
// de-interleave, per-axis move, bounds merge and re-interleave
// ----------------------------------------------------------------------------
module mncc_calc (
    input  mncc_pkg::t_req i_req,
    output mncc_pkg::t_res o_res
);
    import mncc_pkg::*;

    logic [CMP_BITS-1:0]   lvl_w;
    logic [CMP_BITS-1:0]   lvl_c;
    logic [CMP_BITS-1:0]   cell_sh_w;
    t_shift                shift;
    logic [COORD_BITS-1:0] cx, cy, cz;
    logic [COORD_BITS-1:0] nx, ny, nz;
    logic                  out_x, out_y, out_z;
    logic                  outside;

    // levels past the grid act as the finest level
    assign lvl_w     = CMP_BITS'(i_req.level);
    assign lvl_c     = (lvl_w > CMP_BITS'(COORD_BITS)) ? CMP_BITS'(COORD_BITS) : lvl_w;
    assign cell_sh_w = CMP_BITS'(COORD_BITS) - lvl_c;

    assign shift.cell_sh    = cell_sh_w[SH_BITS-1:0];
    assign shift.quarter_en = (lvl_c <= CMP_BITS'(COORD_BITS - 2));
    assign shift.quarter_sh = cell_sh_w[SH_BITS-1:0] - SH_BITS'(2);

    assign cx = mncc_pick(i_req.code, LANE_X);
    assign cy = mncc_pick(i_req.code, LANE_Y);
    assign cz = mncc_pick(i_req.code, LANE_Z);

    mncc_axis u_axis_x (
        .i_coord   (cx),
        .i_step    (i_req.step_x),
        .i_sub     (i_req.sub_x),
        .i_shift   (shift),
        .o_coord   (nx),
        .o_outside (out_x)
    );

    mncc_axis u_axis_y (
        .i_coord   (cy),
        .i_step    (i_req.step_y),
        .i_sub     (i_req.sub_y),
        .i_shift   (shift),
        .o_coord   (ny),
        .o_outside (out_y)
    );

    mncc_axis u_axis_z (
        .i_coord   (cz),
        .i_step    (i_req.step_z),
        .i_sub     (i_req.sub_z),
        .i_shift   (shift),
        .o_coord   (nz),
        .o_outside (out_z)
    );

    assign outside       = out_x | out_y | out_z;
    assign o_res.outside = outside;
    assign o_res.code    = outside ? '0 : mncc_weave(nx, ny, nz);

endmodule

FILE: design/morton_neighbor_cell_code_unit.sv
// ----------------------------------------------------------------------------
// morton_neighbor_cell_code_unit
// neighbor lookup on 3d morton cell codes with optional quarter-cell offset
// ----------------------------------------------------------------------------
// usage
//   requests enter on the s_axis channel, one per accepted tvalid/tready beat:
//   cell code, octree level, whole-cell direction and quarter-cell offset per
//   axis. each request gives exactly one response on the m_axis channel: the
//   neighbor's morton code in tdata and the outside-grid flag in tuser (code
//   is zero when the flag is set).
//   path: an accepted request sits in the input register until the result
//   register takes it, and is presented on m_axis from the result register.
//   throughput: one request per cycle while m_axis tready is high, set by
//   the single pass of shuffle and 13-bit add logic between the input and
//   result registers.
//   stall: when m_axis tready is low the result register holds; the input
//   register still takes one more request, after which s_axis tready drops
//   until the result moves on. nothing is dropped or repeated.
//   reset: synchronous, active low; both stages are emptied, no response is
//   pending afterwards. the unit has no configuration and no state between
//   requests.
// ----------------------------------------------------------------------------
`include "morton_neighbor_cell_code_unit_macros.svh"

module morton_neighbor_cell_code_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: cell_code, cell_level, step_x, step_y, step_z, sub_x, sub_y, sub_z
    input  logic [mncc_pkg::IN_DATA_BITS-1:0]    i_s_axis_tdata,
    // response channel
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // tdata: neighbor_code
    output logic [mncc_pkg::OUT_DATA_BITS-1:0]   o_m_axis_tdata,
    // tuser: outside_grid
    output logic                                 o_m_axis_tuser
);
    import mncc_pkg::*;

    // pipeline control
    logic   r_req_valid;
    logic   r_res_valid;
    logic   n_req_valid;
    logic   n_res_valid;
    logic   res_load;
    logic   req_load;

    // payload
    t_req   r_req;
    t_req   n_req;
    t_res   r_res;
    t_res   n_res;

    // result register loads when empty or being drained
    assign res_load = r_req_valid && (!r_res_valid || i_m_axis_tready);
    // input register loads when empty or moving into the result register
    assign o_s_axis_tready = !r_req_valid || res_load;
    assign req_load        = i_s_axis_tvalid && o_s_axis_tready;

    // unpack request beat
    always_comb begin
        n_req.code   = i_s_axis_tdata[CODE_BITS-1:0];
        n_req.level  = i_s_axis_tdata[LEVEL_LSB +: LVL_BITS];
        n_req.step_x = i_s_axis_tdata[STEP_X_LSB +: 2];
        n_req.step_y = i_s_axis_tdata[STEP_Y_LSB +: 2];
        n_req.step_z = i_s_axis_tdata[STEP_Z_LSB +: 2];
        n_req.sub_x  = i_s_axis_tdata[SUB_X_LSB +: 2];
        n_req.sub_y  = i_s_axis_tdata[SUB_Y_LSB +: 2];
        n_req.sub_z  = i_s_axis_tdata[SUB_Z_LSB +: 2];
    end

    // single pass of neighbor arithmetic
    mncc_calc u_calc (
        .i_req (r_req),
        .o_res (n_res)
    );

    // stage occupancy
    always_comb begin
        n_req_valid = r_req_valid;
        n_res_valid = r_res_valid;
        if (r_res_valid && i_m_axis_tready) begin
            n_res_valid = 1'b0;
        end
        if (res_load) begin
            n_res_valid = 1'b1;
            n_req_valid = 1'b0;
        end
        if (req_load) begin
            n_req_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_req_valid <= n_req_valid;
            r_res_valid <= n_res_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (req_load) begin
            r_req <= n_req;
        end
        if (res_load) begin
            r_res <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_res_valid;
    assign o_m_axis_tdata  = OUT_DATA_BITS'(r_res.code);
    assign o_m_axis_tuser  = r_res.outside;

    // an outside result always carries a zero code
    `MNCC_ASSERT_NOW(a_outside_zero, i_clk, i_rst_n,
        r_res_valid && r_res.outside, r_res.code == '0)
    // an accepted request always lands in the input register
    `MNCC_ASSERT_NEXT(a_req_lands, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, r_req_valid)
    // a held request moves on whenever the result register is free
    `MNCC_ASSERT_NEXT(a_req_moves, i_clk, i_rst_n,
        r_req_valid && !r_res_valid, r_res_valid)

endmodule
